// ===== design/itar_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
package itar_pkg;

	localparam int unsigned VALUE_BITS = 64;
	localparam int unsigned DEC_BITS   = 32;
	localparam int unsigned BCD_DIGITS = 10;
	localparam int unsigned BCD_W      = BCD_DIGITS * 4;
	localparam int unsigned PAD_RAW    = ((VALUE_BITS + 11) / 12) * 12;
	localparam int unsigned PAD_BITS   = (PAD_RAW < 48) ? 48 : PAD_RAW;
	localparam int unsigned DIG_BIN    = PAD_BITS;
	localparam int unsigned DIG_OCT    = PAD_BITS / 3;
	localparam int unsigned DIG_HEX    = PAD_BITS / 4;
	localparam int unsigned CNT_W      = $clog2(PAD_BITS + 1);
	localparam int unsigned DEC_RADIX  = 10;

	localparam logic [2:0] OP_DEC  = 3'd0;
	localparam logic [2:0] OP_OCT  = 3'd1;
	localparam logic [2:0] OP_BIN  = 3'd2;
	localparam logic [2:0] OP_HEXU = 3'd3;
	localparam logic [2:0] OP_HEXL = 3'd4;

	localparam logic [2:0] SHIFT_BIN = 3'd1;
	localparam logic [2:0] SHIFT_OCT = 3'd3;
	localparam logic [2:0] SHIFT_HEX = 3'd4;

	localparam logic [6:0] CH_ZERO  = 7'd48;
	localparam logic [6:0] CH_UPPER = 7'd55;
	localparam logic [6:0] CH_LOWER = 7'd87;
	localparam logic [6:0] CH_MINUS = 7'd45;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         opcode;
	} in_word_t;

	typedef struct packed {
		logic [6:0]  char_code;
		logic        last;
		logic        empty_res;
		logic [31:0] total_count;
	} out_word_t;

	typedef enum logic [1:0] {
		K_EMPTY,
		K_DEC,
		K_RADIX
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic                  neg;
		logic                  upper;
		logic [2:0]            dshift;
		logic [CNT_W-1:0]      ndig;
		logic [VALUE_BITS-1:0] mag;
	} cmd_t;

endpackage

// ===== design/itar_front.sv =====
// Front end: accepts input words, classifies them and queues commands for the back end.
module itar_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  itar_pkg::in_word_t item,
	output logic             cmd_valid,
	output itar_pkg::cmd_t   cmd,
	input  logic             cmd_pop
);

	itar_pkg::cmd_t cls;
	itar_pkg::cmd_t cmdq_q [2];
	logic [1:0] cnt_q;
	logic       wptr_q;
	logic       rptr_q;
	logic       wr;
	logic       rd;
	logic [itar_pkg::VALUE_BITS-1:0] v;
	logic [itar_pkg::DEC_BITS-1:0]   x;

	assign v = item.value[itar_pkg::VALUE_BITS-1:0];
	assign x = item.value[itar_pkg::DEC_BITS-1:0];

	always_comb begin
		cls        = '0;
		cls.kind   = itar_pkg::K_EMPTY;
		cls.dshift = itar_pkg::SHIFT_HEX;
		cls.ndig   = itar_pkg::CNT_W'(itar_pkg::DIG_HEX);
		case (item.opcode)
			itar_pkg::OP_DEC: begin
				cls.kind = itar_pkg::K_DEC;
				cls.neg  = x[itar_pkg::DEC_BITS-1];
				cls.mag  = itar_pkg::VALUE_BITS'(x[itar_pkg::DEC_BITS-1] ? (~x + 32'd1) : x);
			end
			itar_pkg::OP_OCT, itar_pkg::OP_BIN, itar_pkg::OP_HEXU, itar_pkg::OP_HEXL: begin
				cls.kind = (v == '0 || v[itar_pkg::VALUE_BITS-1]) ? itar_pkg::K_EMPTY
					: itar_pkg::K_RADIX;
				cls.mag   = v;
				cls.upper = (item.opcode == itar_pkg::OP_HEXU);
				if (item.opcode == itar_pkg::OP_OCT) begin
					cls.dshift = itar_pkg::SHIFT_OCT;
					cls.ndig   = itar_pkg::CNT_W'(itar_pkg::DIG_OCT);
				end else if (item.opcode == itar_pkg::OP_BIN) begin
					cls.dshift = itar_pkg::SHIFT_BIN;
					cls.ndig   = itar_pkg::CNT_W'(itar_pkg::DIG_BIN);
				end
			end
			default: cls.kind = itar_pkg::K_EMPTY;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmdq_q[rptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
		end else begin
			if (wr)
				wptr_q <= !wptr_q;
			if (rd)
				rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			cmdq_q[wptr_q] <= cls;
	end

endmodule

// ===== design/itar_back.sv =====
// Back end: BCD conversion, digit emission and the result queue.
module itar_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  itar_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output itar_pkg::out_word_t result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SIGN,
		S_CONV,
		S_EMIT,
		S_EMPTY
	} state_t;

	state_t state_q;
	logic [itar_pkg::PAD_BITS-1:0] work_q;
	logic [itar_pkg::DEC_BITS-1:0] bin_q;
	logic [itar_pkg::CNT_W-1:0]    cnt_q;
	logic [2:0]                    dshift_q;
	logic                          upper_q;
	logic                          started_q;
	logic [31:0]                   written_q;

	itar_pkg::out_word_t oq_q [2];
	logic [1:0] oq_cnt_q;
	logic       oq_wptr_q;
	logic       oq_rptr_q;
	logic       oq_full;
	logic       oq_rd;

	itar_pkg::out_word_t prod;
	logic                prod_valid;
	logic                adv;
	logic                emit_dig;
	logic                last_dig;
	logic [3:0]          top4;
	logic [3:0]          digit;
	logic [6:0]          chr;
	logic [itar_pkg::BCD_W-1:0] bcd_adj;

	assign top4     = work_q[itar_pkg::PAD_BITS-1 -: 4];
	assign digit    = top4 >> (3'd4 - dshift_q);
	assign last_dig = (cnt_q == itar_pkg::CNT_W'(1));
	assign emit_dig = started_q || digit != 4'd0 || last_dig;

	always_comb begin
		if (digit < 4'(itar_pkg::DEC_RADIX))
			chr = itar_pkg::CH_ZERO + {3'b000, digit};
		else if (upper_q)
			chr = itar_pkg::CH_UPPER + {3'b000, digit};
		else
			chr = itar_pkg::CH_LOWER + {3'b000, digit};
	end

	always_comb begin
		for (int i = 0; i < int'(itar_pkg::BCD_DIGITS); i++) begin
			if (work_q[4*i +: 4] >= 4'd5)
				bcd_adj[4*i +: 4] = work_q[4*i +: 4] + 4'd3;
			else
				bcd_adj[4*i +: 4] = work_q[4*i +: 4];
		end
	end

	always_comb begin
		prod_valid       = 1'b0;
		adv              = 1'b0;
		prod             = '0;
		prod.total_count = written_q + 32'd1;
		case (state_q)
			S_SIGN: begin
				prod_valid     = !oq_full;
				prod.char_code = itar_pkg::CH_MINUS;
			end
			S_EMIT: begin
				prod_valid     = emit_dig && !oq_full;
				adv            = !emit_dig || !oq_full;
				prod.char_code = chr;
				prod.last      = last_dig;
			end
			S_EMPTY: begin
				prod_valid       = !oq_full;
				prod.last        = 1'b1;
				prod.empty_res   = 1'b1;
				prod.total_count = written_q;
			end
			default: prod_valid = 1'b0;
		endcase
	end

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			work_q    <= '0;
			bin_q     <= '0;
			cnt_q     <= '0;
			dshift_q  <= itar_pkg::SHIFT_HEX;
			upper_q   <= 1'b0;
			started_q <= 1'b0;
			written_q <= '0;
		end else begin
			if (prod_valid && !prod.empty_res)
				written_q <= written_q + 32'd1;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						upper_q   <= cmd.upper;
						dshift_q  <= cmd.dshift;
						started_q <= 1'b0;
						case (cmd.kind)
							itar_pkg::K_DEC: begin
								work_q  <= '0;
								bin_q   <= cmd.mag[itar_pkg::DEC_BITS-1:0];
								cnt_q   <= itar_pkg::CNT_W'(itar_pkg::DEC_BITS);
								state_q <= cmd.neg ? S_SIGN : S_CONV;
							end
							itar_pkg::K_RADIX: begin
								work_q  <= itar_pkg::PAD_BITS'(cmd.mag);
								cnt_q   <= cmd.ndig;
								state_q <= S_EMIT;
							end
							default: state_q <= S_EMPTY;
						endcase
					end
				end
				S_SIGN: begin
					if (!oq_full)
						state_q <= S_CONV;
				end
				S_CONV: begin
					work_q <= itar_pkg::PAD_BITS'({bcd_adj[itar_pkg::BCD_W-2:0],
						bin_q[itar_pkg::DEC_BITS-1]});
					bin_q  <= bin_q << 1;
					if (last_dig) begin
						cnt_q    <= itar_pkg::CNT_W'(itar_pkg::DIG_HEX);
						dshift_q <= itar_pkg::SHIFT_HEX;
						state_q  <= S_EMIT;
					end else begin
						cnt_q <= cnt_q - itar_pkg::CNT_W'(1);
					end
				end
				S_EMIT: begin
					if (adv) begin
						work_q    <= work_q << dshift_q;
						cnt_q     <= cnt_q - itar_pkg::CNT_W'(1);
						started_q <= emit_dig;
						if (last_dig)
							state_q <= S_IDLE;
					end
				end
				S_EMPTY: begin
					if (!oq_full)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign oq_full = (oq_cnt_q == 2'd2);
	assign empty   = (oq_cnt_q == 2'd0);
	assign result  = oq_q[oq_rptr_q];
	assign oq_rd   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_cnt_q  <= '0;
			oq_wptr_q <= 1'b0;
			oq_rptr_q <= 1'b0;
		end else begin
			if (prod_valid)
				oq_wptr_q <= !oq_wptr_q;
			if (oq_rd)
				oq_rptr_q <= !oq_rptr_q;
			oq_cnt_q <= oq_cnt_q + {1'b0, prod_valid} - {1'b0, oq_rd};
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid)
			oq_q[oq_wptr_q] <= prod;
	end

endmodule

// ===== design/integer_to_ascii_radix.sv =====
// Integer to ASCII formatter, top level: front classifier, command queue, back formatter.
// Throughput: one word at a time in the back end. A word is loaded, then steps
// through its digit positions: 72 binary, 24 octal, 18 hex (72-bit padded shifter),
// and for decimal a '-' sign if negative, a 32-bit BCD conversion, then 18 digit
// positions; an empty result is a single word.
// Reset (arst_n low) empties both queues, idles the back end and zeroes the count.
module integer_to_ascii_radix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  itar_pkg::in_word_t  item,
	output logic                empty,
	input  logic                pop,
	output itar_pkg::out_word_t result
);

	logic           cmd_valid;
	logic           cmd_pop;
	itar_pkg::cmd_t cmd;

	itar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	itar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.empty_res |-> result.last && result.char_code == 7'd0)
		else $error("empty result word not final or carries a character");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.empty_res |->
			(result.char_code >= 7'd48 && result.char_code <= 7'd57) ||
			(result.char_code >= 7'd65 && result.char_code <= 7'd70) ||
			(result.char_code >= 7'd97 && result.char_code <= 7'd102) ||
			result.char_code == 7'd45)
		else $error("character outside digit set");

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_pop |=> cmd_valid && $stable(cmd))
		else $error("queued command changed before the back end took it");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for integer_to_ascii_radix: character predictor, scoreboard and queue-side drivers.
`timescale 1ns / 100ps

import itar_pkg::*;

class char_scoreboard;
	out_word_t   pending_chars[$];
	logic [31:0] chars_written;
	int          errors;

	function new();
		chars_written = '0;
		errors = 0;
	endfunction

	function void add_char(logic [6:0] code);
		out_word_t w;
		chars_written = chars_written + 32'd1;
		w.char_code = code;
		w.last = 1'b0;
		w.empty_res = 1'b0;
		w.total_count = chars_written;
		pending_chars.push_back(w);
	endfunction

	function void add_empty();
		out_word_t w;
		w.char_code = '0;
		w.last = 1'b1;
		w.empty_res = 1'b1;
		w.total_count = chars_written;
		pending_chars.push_back(w);
	endfunction

	// Format one accepted word into its expected characters.
	function void note_input(in_word_t w);
		logic [31:0] x;
		logic [31:0] mag;
		logic [63:0] v;
		logic [63:0] dmask;
		int          shamt;
		int          digs[64];
		int          nd;
		out_word_t   tail;
		nd = 0;
		case (w.opcode)
			OP_DEC: begin
				x = w.value[31:0];
				if (x[31]) begin
					add_char(CH_MINUS);
					mag = -x;
				end else begin
					mag = x;
				end
				do begin
					digs[nd] = int'(mag % DEC_RADIX);
					mag = mag / DEC_RADIX;
					nd++;
				end while (mag != 0);
				for (int i = nd - 1; i >= 0; i--)
					add_char(CH_ZERO + 7'(digs[i]));
			end
			OP_OCT, OP_BIN, OP_HEXU, OP_HEXL: begin
				v = w.value;
				if (v == '0 || v[63]) begin
					add_empty();
					return;
				end
				shamt = (w.opcode == OP_OCT) ? int'(SHIFT_OCT) :
				        (w.opcode == OP_BIN) ? int'(SHIFT_BIN) : int'(SHIFT_HEX);
				dmask = (64'd1 << shamt) - 64'd1;
				while (v != '0) begin
					digs[nd] = int'(v & dmask);
					v = v >> shamt;
					nd++;
				end
				for (int i = nd - 1; i >= 0; i--) begin
					if (digs[i] < 10)
						add_char(CH_ZERO + 7'(digs[i]));
					else if (w.opcode == OP_HEXU)
						add_char(CH_UPPER + 7'(digs[i]));
					else
						add_char(CH_LOWER + 7'(digs[i]));
				end
			end
			default: begin
				add_empty();
				return;
			end
		endcase
		tail = pending_chars.pop_back();
		tail.last = 1'b1;
		pending_chars.push_back(tail);
	endfunction

	function void check_result(out_word_t r);
		out_word_t exp_w;
		if (pending_chars.size() == 0) begin
			$error("unexpected word: char_code %0d last %0d empty_res %0d total_count %0d",
				r.char_code, r.last, r.empty_res, r.total_count);
			errors++;
			return;
		end
		exp_w = pending_chars.pop_front();
		if (r.char_code !== exp_w.char_code) begin
			$error("char_code: expected %0d, actual %0d", exp_w.char_code, r.char_code);
			errors++;
		end
		if (r.last !== exp_w.last) begin
			$error("last: expected %0d, actual %0d", exp_w.last, r.last);
			errors++;
		end
		if (r.empty_res !== exp_w.empty_res) begin
			$error("empty_res: expected %0d, actual %0d", exp_w.empty_res, r.empty_res);
			errors++;
		end
		if (r.total_count !== exp_w.total_count) begin
			$error("total_count: expected %0d, actual %0d", exp_w.total_count, r.total_count);
			errors++;
		end
	endfunction
endclass

module tb_top;

	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RAND_PER_PHASE = 105;
	localparam int TAIL_CYCLES    = 200;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	logic      full;
	logic      empty;
	in_word_t  item   = '0;
	out_word_t result;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;

	char_scoreboard sb = new();

	integer_to_ascii_radix dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
		pop <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic send_word(in_word_t w);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		sb.note_input(w);
	endtask

	task automatic send_value(logic [63:0] v, logic [2:0] op);
		in_word_t w;
		w.value = v;
		w.opcode = op;
		send_word(w);
	endtask

	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending_chars.size() != 0);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          nbits;
		v = {$urandom, $urandom};
		nbits = $urandom_range(1, 64);
		if (nbits < 64)
			v &= (64'd1 << nbits) - 64'd1;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = ~v;
			2: v[31:0] = -v[31:0];
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_random(int n);
		logic [2:0] ops[5];
		logic [2:0] op;
		ops = '{OP_DEC, OP_OCT, OP_BIN, OP_HEXU, OP_HEXL};
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				op = 3'($urandom_range(int'(OP_HEXL) + 1, 7));
			else
				op = ops[$urandom_range(0, 4)];
			send_value(rand_value(), op);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		send_value(64'd0, OP_DEC);
		send_value(64'd1, OP_DEC);
		send_value(-64'sd1, OP_DEC);
		send_value(64'h0000_0000_7FFF_FFFF, OP_DEC);
		send_value(64'h0000_0000_8000_0000, OP_DEC);
		send_value(64'hFFFF_FFFF_8000_0000, OP_DEC);
		send_value(64'h1234_5678_0000_000A, OP_DEC);
		send_value(-64'sd9, OP_DEC);
		send_value(64'h7FFF_FFFF_FFFF_FFFF, OP_OCT);
		send_value(64'd8, OP_OCT);
		send_value(64'd0, OP_OCT);
		send_value(-64'sd1, OP_OCT);
		send_value(64'h7FFF_FFFF_FFFF_FFFF, OP_BIN);
		send_value(64'd1, OP_BIN);
		send_value(64'h8000_0000_0000_0000, OP_BIN);
		send_value(64'h7EAD_BEEF_CAFE_F00D, OP_HEXU);
		send_value(64'h0000_0000_00AB_CDEF, OP_HEXU);
		send_value(64'd0, OP_HEXU);
		send_value(64'h7EAD_BEEF_CAFE_F00D, OP_HEXL);
		send_value(64'h0000_0000_00AB_CDEF, OP_HEXL);
		send_value(-64'sd2, OP_HEXL);
		send_value(64'd255, OP_HEXL + 3'd1);
		send_value(64'd255, OP_HEXL + 3'd2);
		send_value(64'd255, OP_HEXL + 3'd3);

		send_random(RAND_PER_PHASE);
		drain();

		send_idle_pct = 46;
		recv_stall_pct = 0;
		send_random(RAND_PER_PHASE);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 46;
		send_random(RAND_PER_PHASE);
		drain();

		send_idle_pct = 26;
		recv_stall_pct = 26;
		send_random(RAND_PER_PHASE);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
design/itar_pkg.sv
design/itar_front.sv
design/itar_back.sv
design/integer_to_ascii_radix.sv
dv/tb_top.sv
